/* hw/rtl/esc_pkg.sv */
// Shared types, constants and arithmetic helpers for the environmental
// sensor compensation pipeline. No dependencies.
`timescale 1ns / 1ps

package esc_pkg;

    // Pipeline depths
    localparam int FrontLat  = 11;
    localparam int TfLat     = 4;
    localparam int HumLat    = 11;
    localparam int DivLat    = 32;
    localparam int BackLat   = 3;
    localparam int TotalLat  = FrontLat + DivLat + BackLat;
    localparam int HumAlign  = TotalLat - TfLat - HumLat;

    // Configuration register indexes
    localparam logic [2:0] RegTempCalib  = 3'd0;
    localparam logic [2:0] RegPressCalA  = 3'd1;
    localparam logic [2:0] RegPressCalB  = 3'd2;
    localparam logic [2:0] RegPressCalC  = 3'd3;
    localparam logic [2:0] RegHumCalA    = 3'd4;
    localparam logic [2:0] RegHumCalB    = 3'd5;

    // Output limits and scheme constants
    localparam logic signed [31:0] TempMin   = -32'sd4000;
    localparam logic signed [31:0] TempMax   = 32'sd8500;
    localparam logic [31:0]        PressMin  = 32'd30000;
    localparam logic [31:0]        PressMax  = 32'd110000;
    localparam logic signed [31:0] HumRawCap = 32'sd419430400;

    typedef struct packed {
        logic [47:0] temp;
        logic [47:0] press_a;
        logic [47:0] press_b;
        logic [47:0] press_c;
        logic [31:0] hum_a;
        logic [31:0] hum_b;
    } t_calib;

    // Sideband that travels with a transaction through the divider
    typedef struct packed {
        logic [2:0]         mask;
        logic signed [14:0] temp;
        logic               post;
        logic               zero;
    } t_side;

    // Signed division by 2**k, truncating toward zero
    function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
                                                   input logic [4:0] k);
        logic signed [31:0] bias;
        bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (x + bias) >>> k;
    endfunction

    function automatic logic signed [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic signed [31:0] sx12(input logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic logic signed [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

/* hw/rtl/esc_front.sv */
// Fine temperature, temperature output and pressure divider operands.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [19:0]         i_raw_t,
    input  logic [19:0]         i_raw_p,
    input  logic [15:0]         i_raw_h,
    input  logic [2:0]          i_mask,
    input  esc_pkg::t_calib     i_calib,
    output logic signed [31:0]  o_tf,
    output logic [15:0]         o_raw_h,
    output logic                o_valid,
    output logic [31:0]         o_dividend,
    output logic [31:0]         o_divisor,
    output esc_pkg::t_side      o_side
);

    logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
    logic signed [31:0] tmp5;
    logic [esc_pkg::FrontLat-1:0] r_vld;
    logic [2:0] r_mask [esc_pkg::FrontLat];
    logic [19:0] r_rp [9];
    logic [15:0] r_rh [4];
    logic signed [14:0] r_temp [7];
    logic signed [31:0] r_a0, r_b0, r_am, r_bb, r_a, r_bm, r_tf, r_pa;
    logic signed [31:0] r_c, r_m5, r_m2, r_b6, r_d3, r_b5, r_c2, r_bs8, r_ap;
    logic signed [31:0] r_am1, r_bs9, r_dv;
    logic [31:0] r_numer, r_dividend, r_divisor;
    logic r_post, r_zero;
    logic signed [14:0] n_temp;

    // Calibration field decode
    assign t1 = {16'd0, i_calib.temp[15:0]};
    assign t2 = esc_pkg::sx16(i_calib.temp[31:16]);
    assign t3 = esc_pkg::sx16(i_calib.temp[47:32]);
    assign p1 = {16'd0, i_calib.press_a[15:0]};
    assign p2 = esc_pkg::sx16(i_calib.press_a[31:16]);
    assign p3 = esc_pkg::sx16(i_calib.press_a[47:32]);
    assign p4 = esc_pkg::sx16(i_calib.press_b[15:0]);
    assign p5 = esc_pkg::sx16(i_calib.press_b[31:16]);
    assign p6 = esc_pkg::sx16(i_calib.press_b[47:32]);

    // Clamp temperature in 0.01 degC
    always_comb begin
        tmp5 = esc_pkg::sdiv_p2(r_tf * 32'sd5 + 32'sd128, 5'd8);
        if (tmp5 < esc_pkg::TempMin) begin
            n_temp = esc_pkg::TempMin[14:0];
        end else if (tmp5 > esc_pkg::TempMax) begin
            n_temp = esc_pkg::TempMax[14:0];
        end else begin
            n_temp = tmp5[14:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[esc_pkg::FrontLat-2:0], i_valid};
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        r_mask[0] <= i_mask;
        for (int i = 1; i < esc_pkg::FrontLat; i++) r_mask[i] <= r_mask[i-1];
        r_rp[0] <= i_raw_p;
        for (int i = 1; i < 9; i++) r_rp[i] <= r_rp[i-1];
        r_rh[0] <= i_raw_h;
        for (int i = 1; i < 4; i++) r_rh[i] <= r_rh[i-1];
        r_temp[0] <= n_temp;
        for (int i = 1; i < 7; i++) r_temp[i] <= r_temp[i-1];
        // stage 1
        r_a0 <= {15'd0, i_raw_t[19:3]} - (t1 <<< 1);
        r_b0 <= {16'd0, i_raw_t[19:4]} - t1;
        // stage 2
        r_am <= r_a0 * t2;
        r_bb <= r_b0 * r_b0;
        // stage 3
        r_a  <= esc_pkg::sdiv_p2(r_am, 5'd11);
        r_bm <= esc_pkg::sdiv_p2(r_bb, 5'd12) * t3;
        // stage 4: fine temperature
        r_tf <= r_a + esc_pkg::sdiv_p2(r_bm, 5'd14);
        // stage 5
        r_pa <= esc_pkg::sdiv_p2(r_tf, 5'd1) - 32'sd64000;
        // stage 6
        r_c  <= esc_pkg::sdiv_p2(r_pa, 5'd2) * esc_pkg::sdiv_p2(r_pa, 5'd2);
        r_m5 <= r_pa * p5;
        r_m2 <= p2 * r_pa;
        // stage 7
        r_b6 <= esc_pkg::sdiv_p2(r_c, 5'd11) * p6;
        r_d3 <= p3 * esc_pkg::sdiv_p2(r_c, 5'd13);
        r_b5 <= r_m5 <<< 1;
        r_c2 <= esc_pkg::sdiv_p2(r_m2, 5'd1);
        // stage 8
        r_bs8 <= esc_pkg::sdiv_p2(r_b6 + r_b5, 5'd2) + (p4 <<< 16);
        r_ap  <= esc_pkg::sdiv_p2(esc_pkg::sdiv_p2(r_d3, 5'd3) + r_c2, 5'd18);
        // stage 9
        r_am1 <= (32'sd32768 + r_ap) * p1;
        r_bs9 <= r_bs8;
        // stage 10
        r_dv    <= esc_pkg::sdiv_p2(r_am1, 5'd15);
        r_numer <= ((32'd1048576 - {12'd0, r_rp[8]})
                    - esc_pkg::sdiv_p2(r_bs9, 5'd12)) * 32'd3125;
        // stage 11: pre-scale dividend
        r_zero     <= (r_dv == 32'sd0);
        r_post     <= r_numer[31];
        r_dividend <= r_numer[31] ? r_numer : {r_numer[30:0], 1'b0};
        r_divisor  <= r_dv;
    end

    assign o_tf       = r_tf;
    assign o_raw_h    = r_rh[3];
    assign o_valid    = r_vld[esc_pkg::FrontLat-1];
    assign o_dividend = r_dividend;
    assign o_divisor  = r_divisor;
    assign o_side     = '{mask: r_mask[esc_pkg::FrontLat-1], temp: r_temp[6],
                          post: r_post, zero: r_zero};

endmodule

/* hw/rtl/esc_hum.sv */
// Humidity compensation stages plus alignment delay to the output stage.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_hum (
    input  logic                i_clk,
    input  logic signed [31:0]  i_tf,
    input  logic [15:0]         i_raw_h,
    input  esc_pkg::t_calib     i_calib,
    output logic [16:0]         o_hum
);

    logic signed [31:0] h1, h2, h3, h4, h5, h6, vf;
    logic signed [31:0] r_v1, r_v4a, r_m6, r_m3, r_v2r, r_v5 [5], r_v2b, r_v3b;
    logic signed [31:0] r_p, r_v4, r_q, r_v2c, r_v3, r_v3d, r_v3e, r_s, r_t;
    logic [15:0] r_rh;
    logic [16:0] n_hum;
    logic [16:0] r_al [esc_pkg::HumAlign];

    assign h1 = {24'd0, i_calib.hum_a[7:0]};
    assign h2 = esc_pkg::sx16(i_calib.hum_a[23:8]);
    assign h3 = {24'd0, i_calib.hum_a[31:24]};
    assign h4 = esc_pkg::sx12(i_calib.hum_b[11:0]);
    assign h5 = esc_pkg::sx12(i_calib.hum_b[23:12]);
    assign h6 = esc_pkg::sx8(i_calib.hum_b[31:24]);

    // Final subtract and clamp
    always_comb begin
        vf = r_v3e - esc_pkg::sdiv_p2(r_t, 5'd4);
        if (vf < 32'sd0) begin
            n_hum = '0;
        end else if (vf > esc_pkg::HumRawCap) begin
            n_hum = esc_pkg::HumRawCap[28:12];
        end else begin
            n_hum = vf[28:12];
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1  <= i_tf - 32'sd76800;
        r_rh  <= i_raw_h;
        r_v4a <= h5 * r_v1;
        r_m6  <= r_v1 * h6;
        r_m3  <= r_v1 * h3;
        r_v2r <= {2'd0, r_rh, 14'd0};
        r_v5[0] <= esc_pkg::sdiv_p2(r_v2r - (h4 <<< 20) - r_v4a + 32'sd16384, 5'd15);
        for (int i = 1; i < 5; i++) r_v5[i] <= r_v5[i-1];
        r_v2b <= esc_pkg::sdiv_p2(r_m6, 5'd10);
        r_v3b <= esc_pkg::sdiv_p2(r_m3, 5'd11);
        r_p   <= r_v2b * (r_v3b + 32'sd32768);
        r_v4  <= esc_pkg::sdiv_p2(r_p, 5'd10) + 32'sd2097152;
        r_q   <= r_v4 * h2;
        r_v2c <= esc_pkg::sdiv_p2(r_q + 32'sd8192, 5'd14);
        r_v3  <= r_v5[4] * r_v2c;
        r_s   <= esc_pkg::sdiv_p2(r_v3, 5'd15) * esc_pkg::sdiv_p2(r_v3, 5'd15);
        r_v3d <= r_v3;
        r_t   <= esc_pkg::sdiv_p2(r_s, 5'd7) * h1;
        r_v3e <= r_v3d;
        // hold result until the pressure side catches up
        r_al[0] <= n_hum;
        for (int i = 1; i < esc_pkg::HumAlign; i++) r_al[i] <= r_al[i-1];
    end

    assign o_hum = r_al[esc_pkg::HumAlign-1];

endmodule

/* hw/rtl/esc_div.sv */
// Pipelined restoring divider, 32-bit unsigned, one quotient bit per stage.
// Depends on esc_pkg for the sideband type and the divider depth.
`timescale 1ns / 1ps

module esc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [31:0]     i_dividend,
    input  logic [31:0]     i_divisor,
    input  esc_pkg::t_side  i_side,
    output logic            o_valid,
    output logic [31:0]     o_quotient,
    output esc_pkg::t_side  o_side
);

    logic [31:0] r_rem [esc_pkg::DivLat];
    logic [31:0] r_quo [esc_pkg::DivLat];
    logic [31:0] r_den [esc_pkg::DivLat];
    esc_pkg::t_side r_side [esc_pkg::DivLat];
    logic [esc_pkg::DivLat-1:0] r_vld;
    logic [31:0] n_rem [esc_pkg::DivLat];
    logic [31:0] n_quo [esc_pkg::DivLat];

    // One trial subtract per stage
    always_comb begin
        logic [31:0] rem_in, quo_in, den_in;
        logic [32:0] sh;
        for (int i = 0; i < esc_pkg::DivLat; i++) begin
            rem_in = (i == 0) ? 32'd0 : r_rem[(i == 0) ? 0 : i-1];
            quo_in = (i == 0) ? i_dividend : r_quo[(i == 0) ? 0 : i-1];
            den_in = (i == 0) ? i_divisor : r_den[(i == 0) ? 0 : i-1];
            sh = {rem_in, quo_in[31]};
            if (sh >= {1'b0, den_in}) begin
                n_rem[i] = 32'(sh - {1'b0, den_in});
                n_quo[i] = {quo_in[30:0], 1'b1};
            end else begin
                n_rem[i] = sh[31:0];
                n_quo[i] = {quo_in[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[esc_pkg::DivLat-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_den[0]  <= i_divisor;
        r_side[0] <= i_side;
        for (int i = 1; i < esc_pkg::DivLat; i++) begin
            r_den[i]  <= r_den[i-1];
            r_side[i] <= r_side[i-1];
        end
        for (int i = 0; i < esc_pkg::DivLat; i++) begin
            r_rem[i] <= n_rem[i];
            r_quo[i] <= n_quo[i];
        end
    end

    assign o_valid    = r_vld[esc_pkg::DivLat-1];
    assign o_quotient = r_quo[esc_pkg::DivLat-1];
    assign o_side     = r_side[esc_pkg::DivLat-1];

endmodule

/* hw/rtl/esc_back.sv */
// Pressure correction after the divide, clamping, enables and output registers.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [31:0]         i_quotient,
    input  esc_pkg::t_side      i_side,
    input  logic [16:0]         i_hum,
    input  esc_pkg::t_calib     i_calib,
    output logic                o_valid,
    output logic signed [14:0]  o_temp,
    output logic [16:0]         o_press,
    output logic [16:0]         o_hum
);

    logic signed [31:0] p7, p8, p9;
    logic [31:0] press1, pf;
    logic [31:0] r_pr1, r_sq, r_pr2;
    logic signed [31:0] r_fm, r_e, r_f;
    esc_pkg::t_side r_side1, r_side2;
    logic [1:0] r_vld;
    logic r_out_vld;
    logic signed [14:0] r_temp;
    logic [16:0] r_press, r_hum, n_press;

    assign p7 = esc_pkg::sx16(i_calib.press_c[15:0]);
    assign p8 = esc_pkg::sx16(i_calib.press_c[31:16]);
    assign p9 = esc_pkg::sx16(i_calib.press_c[47:32]);

    // Undo the dividend pre-scale
    assign press1 = i_side.post ? {i_quotient[30:0], 1'b0} : i_quotient;

    // Final correction and clamp
    always_comb begin
        pf = r_pr2 + esc_pkg::sdiv_p2(r_e + r_f + p7, 5'd4);
        if (r_side2.zero || pf < esc_pkg::PressMin) begin
            n_press = esc_pkg::PressMin[16:0];
        end else if (pf > esc_pkg::PressMax) begin
            n_press = esc_pkg::PressMax[16:0];
        end else begin
            n_press = pf[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[0], i_valid};
            r_out_vld <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pr1   <= press1;
        r_sq    <= {3'd0, press1[31:3]} * {3'd0, press1[31:3]};
        r_fm    <= {2'd0, press1[31:2]} * p8;
        r_side1 <= i_side;
        r_e     <= esc_pkg::sdiv_p2(p9 * {13'd0, r_sq[31:13]}, 5'd12);
        r_f     <= esc_pkg::sdiv_p2(r_fm, 5'd13);
        r_pr2   <= r_pr1;
        r_side2 <= r_side1;
        r_temp  <= r_side2.mask[1] ? r_side2.temp : '0;
        r_press <= r_side2.mask[0] ? n_press : '0;
        r_hum   <= r_side2.mask[2] ? i_hum : '0;
    end

    assign o_valid = r_out_vld;
    assign o_temp  = r_temp;
    assign o_press = r_press;
    assign o_hum   = r_hum;

endmodule

/* hw/rtl/env_sensor_compensation.sv */
// Top level of the environmental sensor compensation pipeline.
// Depends on esc_pkg, esc_front, esc_hum, esc_div and esc_back.
`timescale 1ns / 1ps

// A sample set is taken at every clock edge with start high and busy low
// (busy is high only in reset), one per cycle with no gaps. Each result
// appears on the output ports for one cycle with o_valid high, after its
// sample set has passed 11 front stages for fine temperature and the
// pressure operands, 32 stages of the bit-per-stage pressure divider and 3
// stages of pressure correction; humidity runs alongside. The receiver cannot
// stall the results. Calibration is written through the cfg channel, which is
// always ready, and must change only while no transaction is in flight.

module env_sensor_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    input  logic [15:0]        i_raw_humidity,
    input  logic [2:0]         i_enable_mask,
    output logic               o_valid,
    output logic signed [14:0] o_temperature_centi,
    output logic [16:0]        o_pressure_pa,
    output logic [16:0]        o_humidity_q10,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);

    esc_pkg::t_calib r_calib;
    esc_pkg::t_side  front_side, div_side;
    logic signed [31:0] tf;
    logic [15:0] tf_raw_h;
    logic front_vld, div_vld, accept;
    logic [31:0] dividend, divisor, quotient;
    logic [16:0] hum_aligned;

    assign busy        = !i_rst_n;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                esc_pkg::RegTempCalib: r_calib.temp    <= i_cfg_data;
                esc_pkg::RegPressCalA: r_calib.press_a <= i_cfg_data;
                esc_pkg::RegPressCalB: r_calib.press_b <= i_cfg_data;
                esc_pkg::RegPressCalC: r_calib.press_c <= i_cfg_data;
                esc_pkg::RegHumCalA:   r_calib.hum_a   <= i_cfg_data[31:0];
                esc_pkg::RegHumCalB:   r_calib.hum_b   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    esc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_raw_t    (i_raw_temperature),
        .i_raw_p    (i_raw_pressure),
        .i_raw_h    (i_raw_humidity),
        .i_mask     (i_enable_mask),
        .i_calib    (r_calib),
        .o_tf       (tf),
        .o_raw_h    (tf_raw_h),
        .o_valid    (front_vld),
        .o_dividend (dividend),
        .o_divisor  (divisor),
        .o_side     (front_side)
    );

    esc_hum u_hum (
        .i_clk   (i_clk),
        .i_tf    (tf),
        .i_raw_h (tf_raw_h),
        .i_calib (r_calib),
        .o_hum   (hum_aligned)
    );

    esc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (front_vld),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .i_side     (front_side),
        .o_valid    (div_vld),
        .o_quotient (quotient),
        .o_side     (div_side)
    );

    esc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (div_vld),
        .i_quotient (quotient),
        .i_side     (div_side),
        .i_hum      (hum_aligned),
        .i_calib    (r_calib),
        .o_valid    (o_valid),
        .o_temp     (o_temperature_centi),
        .o_press    (o_pressure_pa),
        .o_hum      (o_humidity_q10)
    );

    // Every accepted transaction yields a result at the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(esc_pkg::TotalLat) o_valid)
        else $error("result missing at pipeline latency");

    // No result without a transaction accepted at the fixed latency
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, esc_pkg::TotalLat))
        else $error("result without matching transaction");

    // Pressure is disabled or within its clamp window
    a_press_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pressure_pa == 17'd0 ||
                     (o_pressure_pa >= 17'd30000 && o_pressure_pa <= 17'd110000)))
        else $error("pressure outside clamp window");

    // Temperature and humidity stay within their clamps
    a_temp_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_centi >= -15'sd4000 &&
                     o_temperature_centi <= 15'sd8500 &&
                     o_humidity_q10 <= 17'd102400))
        else $error("temperature or humidity outside clamp");

endmodule
